// ----- hw/rtl/rfrc_pkg.sv -----
// Shared types and constants for the radio frame receive checker.
package rfrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int POS_W      = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREADING_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_OPCODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQUEST_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_BIT_MASK  = 3'd5;

  localparam logic [3:0] SF_RESET = 4'd7;

  localparam logic [POS_W-1:0] POS_SENDER    = 9'd0;
  localparam logic [POS_W-1:0] POS_RECIPIENT = 9'd1;
  localparam logic [POS_W-1:0] POS_ID_HIGH   = 9'd2;
  localparam logic [POS_W-1:0] POS_ID_LOW    = 9'd3;
  localparam logic [POS_W-1:0] POS_OPCODE    = 9'd4;
  localparam logic [POS_W-1:0] POS_LENGTH    = 9'd5;
  localparam logic [POS_W-1:0] HEADER_BYTES  = 9'd6;
  localparam logic [POS_W-1:0] POS_MAX       = 9'd511;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_TOO_LONG      = 3'd1,
    STATUS_SHORT_PAYLOAD = 3'd2,
    STATUS_ADDRESS       = 3'd3,
    STATUS_END_MARKER    = 3'd4,
    STATUS_NOISE         = 3'd5,
    STATUS_SHORT_HEADER  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] local_address;
    logic [7:0] end_marker;
    logic [3:0] spreading_factor;
    logic [7:0] ack_opcode;
    logic [7:0] ack_request_mask;
    logic [7:0] config_bit_mask;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  sender_address;
    logic [7:0]  recipient_address;
    logic [15:0] message_id;
    logic [7:0]  opcode;
    logic [7:0]  payload_length;
    status_t     status;
    logic        wants_ack;
    logic        carries_config;
    logic        is_ack;
  } result_t;

endpackage

// ----- hw/rtl/rfrc_cfg_regs.sv -----
// Configuration register file of the radio frame receive checker.
module rfrc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [rfrc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rfrc_pkg::CFG_DATA_W-1:0] wr_data,
  output rfrc_pkg::cfg_t                  cfg
);

  rfrc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_address    <= 8'd0;
      cfg_r.end_marker       <= 8'd0;
      cfg_r.spreading_factor <= rfrc_pkg::SF_RESET;
      cfg_r.ack_opcode       <= 8'd0;
      cfg_r.ack_request_mask <= 8'd0;
      cfg_r.config_bit_mask  <= 8'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        rfrc_pkg::CFG_LOCAL_ADDRESS:    cfg_r.local_address    <= wr_data;
        rfrc_pkg::CFG_END_MARKER:       cfg_r.end_marker       <= wr_data;
        rfrc_pkg::CFG_SPREADING_FACTOR: cfg_r.spreading_factor <= wr_data[3:0];
        rfrc_pkg::CFG_ACK_OPCODE:       cfg_r.ack_opcode       <= wr_data;
        rfrc_pkg::CFG_ACK_REQUEST_MASK: cfg_r.ack_request_mask <= wr_data;
        rfrc_pkg::CFG_CONFIG_BIT_MASK:  cfg_r.config_bit_mask  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/rfrc_parser.sv -----
// Packet state and per-byte header parse, payload echo and summary checks.
module rfrc_parser #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [7:0]           rx_byte,
  input  logic                 last_byte,
  input  logic signed [7:0]    snr_quarter_db,
  input  rfrc_pkg::cfg_t       cfg,
  output logic                 has_result,
  output rfrc_pkg::result_t    result
);

  localparam logic [8:0] LEN_MAX = 9'(PAYLOAD_MAX);

  logic [rfrc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  sender_r, sender_nxt;
  logic [7:0]  recipient_r, recipient_nxt;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        end_err_r, end_err_nxt;
  logic        is_payload;
  logic [7:0]  sf_x10;
  logic signed [8:0] limit;
  logic signed [8:0] snr_ext;
  rfrc_pkg::status_t status;
  logic        flags_on;

  always_comb begin
    sender_nxt    = sender_r;
    recipient_nxt = recipient_r;
    id_nxt        = id_r;
    opcode_nxt    = opcode_r;
    length_nxt    = length_r;
    count_nxt     = count_r;
    end_err_nxt   = end_err_r;
    is_payload    = 1'b0;
    case (pos_r)
      rfrc_pkg::POS_SENDER:    sender_nxt       = rx_byte;
      rfrc_pkg::POS_RECIPIENT: recipient_nxt    = rx_byte;
      rfrc_pkg::POS_ID_HIGH:   id_nxt[15:8]     = rx_byte;
      rfrc_pkg::POS_ID_LOW:    id_nxt[7:0]      = rx_byte;
      rfrc_pkg::POS_OPCODE:    opcode_nxt       = rx_byte;
      rfrc_pkg::POS_LENGTH:    length_nxt       = rx_byte;
      default: begin
        if ({1'b0, length_r} <= LEN_MAX) begin
          if (count_r < length_r) begin
            count_nxt  = count_r + 8'd1;
            is_payload = 1'b1;
          end else if (pos_r == rfrc_pkg::HEADER_BYTES + {1'b0, length_r}) begin
            if (rx_byte != cfg.end_marker) begin
              end_err_nxt = 1'b1;
            end
          end
        end
      end
    endcase
    pos_nxt = (pos_r != rfrc_pkg::POS_MAX) ? pos_r + 9'd1 : pos_r;
  end

  // noise limit 40 - 10*sf in quarter dB
  assign sf_x10  = {1'b0, cfg.spreading_factor, 3'b000} + {3'b000, cfg.spreading_factor, 1'b0};
  assign limit   = 9'sd40 - $signed({1'b0, sf_x10});
  assign snr_ext = {snr_quarter_db[7], snr_quarter_db};

  always_comb begin
    if (pos_nxt < rfrc_pkg::HEADER_BYTES) begin
      status = rfrc_pkg::STATUS_SHORT_HEADER;
    end else if ({1'b0, length_nxt} > LEN_MAX) begin
      status = rfrc_pkg::STATUS_TOO_LONG;
    end else if (count_nxt != length_nxt) begin
      status = rfrc_pkg::STATUS_SHORT_PAYLOAD;
    end else if ((recipient_nxt & cfg.local_address) != cfg.local_address) begin
      status = rfrc_pkg::STATUS_ADDRESS;
    end else if (end_err_nxt) begin
      status = rfrc_pkg::STATUS_END_MARKER;
    end else if (snr_ext <= limit) begin
      status = rfrc_pkg::STATUS_NOISE;
    end else begin
      status = rfrc_pkg::STATUS_OK;
    end
  end

  assign flags_on = (status == rfrc_pkg::STATUS_OK) || (status == rfrc_pkg::STATUS_NOISE);

  always_comb begin
    result = '0;
    result.payload_byte = is_payload ? rx_byte : 8'd0;
    if (last_byte) begin
      result.kind              = 1'b1;
      result.sender_address    = sender_nxt;
      result.recipient_address = recipient_nxt;
      result.message_id        = id_nxt;
      result.opcode            = opcode_nxt;
      result.payload_length    = length_nxt;
      result.status            = status;
      result.wants_ack         = flags_on && ((opcode_nxt & cfg.ack_request_mask) != 8'd0);
      result.carries_config    = flags_on && ((opcode_nxt & cfg.config_bit_mask) != 8'd0);
      result.is_ack            = flags_on && (opcode_nxt == cfg.ack_opcode);
    end
  end

  assign has_result = last_byte || is_payload;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_byte)) begin
      pos_r       <= '0;
      sender_r    <= 8'd0;
      recipient_r <= 8'd0;
      id_r        <= 16'd0;
      opcode_r    <= 8'd0;
      length_r    <= 8'd0;
      count_r     <= 8'd0;
      end_err_r   <= 1'b0;
    end else if (advance) begin
      pos_r       <= pos_nxt;
      sender_r    <= sender_nxt;
      recipient_r <= recipient_nxt;
      id_r        <= id_nxt;
      opcode_r    <= opcode_nxt;
      length_r    <= length_nxt;
      count_r     <= count_nxt;
      end_err_r   <= end_err_nxt;
    end
  end

endmodule

// ----- hw/rtl/radio_frame_receive_checker_top.sv -----
// Top level of the radio frame receive checker.
// Usage:
//   Input channel (in_valid/in_ready) carries one packet byte per beat, with
//   in_last_byte on the final byte and in_snr_quarter_db sampled with it.
//   Result channel (out_valid/out_ready) gives one beat per payload byte
//   (out_kind 0) and one summary beat (out_kind 1) on the flagged last byte.
//   A last byte that is itself payload gives only the summary beat.
//   Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
//   while no packet is in flight.
// Timing:
//   A byte is held in the input register, then parsed and its result
//   captured in the output register. One byte per cycle is sustained while
//   the result channel does not stall.
// Reset: synchronous rst_n clears packet state, empties both registers and
//   restores register defaults (spreading factor 7).
// Stall: while out_ready is low the result beat holds; bytes that make no
//   result still pass, and the first byte that makes one waits in the input
//   register, dropping in_ready.
module radio_frame_receive_checker_top #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_last_byte,
  input  logic signed [7:0]               in_snr_quarter_db,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [7:0]                      out_payload_byte,
  output logic [7:0]                      out_sender_address,
  output logic [7:0]                      out_recipient_address,
  output logic [15:0]                     out_message_id,
  output logic [7:0]                      out_opcode,
  output logic [7:0]                      out_payload_length,
  output logic [2:0]                      out_status,
  output logic                            out_wants_ack,
  output logic                            out_carries_config,
  output logic                            out_is_ack,
  input  logic                            cfg_wr_en,
  input  logic [rfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfrc_pkg::CFG_DATA_W-1:0] cfg_data
);

  rfrc_pkg::cfg_t    cfg;
  rfrc_pkg::result_t res;
  rfrc_pkg::result_t out_r;
  logic              has_result;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic signed [7:0] s1_snr_r;
  logic              s1_go;
  logic              advance;
  logic              out_valid_r;

  rfrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rfrc_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .rx_byte        (s1_byte_r),
    .last_byte      (s1_last_r),
    .snr_quarter_db (s1_snr_r),
    .cfg            (cfg),
    .has_result     (has_result),
    .result         (res)
  );

  assign s1_go    = !has_result || !out_valid_r || out_ready;
  assign advance  = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
      s1_snr_r  <= in_snr_quarter_db;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = out_r.kind;
  assign out_payload_byte      = out_r.payload_byte;
  assign out_sender_address    = out_r.sender_address;
  assign out_recipient_address = out_r.recipient_address;
  assign out_message_id        = out_r.message_id;
  assign out_opcode            = out_r.opcode;
  assign out_payload_length    = out_r.payload_length;
  assign out_status            = out_r.status;
  assign out_wants_ack         = out_r.wants_ack;
  assign out_carries_config    = out_r.carries_config;
  assign out_is_ack            = out_r.is_ack;

endmodule

// ----- hw/rtl/rfrc_checker.sv -----
// Port-level assertions for the radio frame receive checker, bound to the top level.
module rfrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_payload_byte,
  input logic [7:0]  out_sender_address,
  input logic [7:0]  out_recipient_address,
  input logic [15:0] out_message_id,
  input logic [7:0]  out_opcode,
  input logic [7:0]  out_payload_length,
  input logic [2:0]  out_status,
  input logic        out_wants_ack,
  input logic        out_carries_config,
  input logic        out_is_ack
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_kind))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_sender_address == 8'd0 && out_recipient_address == 8'd0
      && out_message_id == 16'd0 && out_opcode == 8'd0 && out_payload_length == 8'd0
      && out_status == rfrc_pkg::STATUS_OK && !out_wants_ack && !out_carries_config
      && !out_is_ack)
    else $error("payload echo carries summary fields");

  a_flags_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && out_status != rfrc_pkg::STATUS_OK
      && out_status != rfrc_pkg::STATUS_NOISE
      |-> !out_wants_ack && !out_carries_config && !out_is_ack)
    else $error("opcode flags set on a rejected packet");

endmodule

bind radio_frame_receive_checker_top rfrc_checker u_rfrc_checker (.*);
